// File: rtl/efp_pkg.sv
// Shared types, record kinds and reset constants for the frame parser.
package efp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned HDR_IDX_W   = 4;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 4'd11;

    localparam logic [BYTE_W-1:0] HEADER_ONE_RESET = 8'h10;
    localparam logic [BYTE_W-1:0] HEADER_TWO_RESET = 8'h81;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_ONE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_TWO = 1'd1;

    localparam logic [KIND_W-1:0] KIND_HEADER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              end_of_frame;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] record_kind;
        logic [WORD_W-1:0] transaction_id;
        logic [WORD_W-1:0] source_class;
        logic [BYTE_W-1:0] source_instance;
        logic [WORD_W-1:0] dest_class;
        logic [BYTE_W-1:0] dest_instance;
        logic [BYTE_W-1:0] service_code;
        logic [BYTE_W-1:0] operation_count;
        logic [BYTE_W-1:0] property_code;
        logic [BYTE_W-1:0] property_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_run;
    } result_t;

    // Work left by one frame byte: an optional record plus an optional end verdict.
    typedef struct packed {
        logic    main_valid;
        result_t main_rec;
        logic    end_valid;
        logic    end_accept;
    } action_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/efp_front.sv
// Front end: walks the frame byte by byte and produces at most one action per byte.
module efp_front (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       take,
    input  efp_pkg::item_t                             item,
    input  logic                                       cfg_write,
    input  logic [efp_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [efp_pkg::BYTE_W-1:0]                 cfg_data,
    output logic                                       act_valid,
    output efp_pkg::action_t                           act
);
    import efp_pkg::*;

    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_CODE    = 3'd1;
    localparam logic [2:0] ST_LEN     = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;
    localparam logic [2:0] ST_FAILED  = 3'd5;

    logic [BYTE_W-1:0]    exp_one_reg, exp_two_reg;
    logic [2:0]           stage_reg, stage_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic                 failed_reg, failed_next;
    logic [BYTE_W-1:0]    ops_reg, ops_next;
    logic [BYTE_W-1:0]    plen_reg, plen_next;
    logic [BYTE_W-1:0]    prop_reg, prop_next;
    logic [WORD_W-1:0]    trans_reg, trans_next;
    logic [WORD_W-1:0]    sclass_reg, sclass_next;
    logic [BYTE_W-1:0]    sinst_reg, sinst_next;
    logic [WORD_W-1:0]    dclass_reg, dclass_next;
    logic [BYTE_W-1:0]    dinst_reg, dinst_next;
    logic [BYTE_W-1:0]    svc_reg, svc_next;
    logic                 complete;
    logic [BYTE_W-1:0]    b;
    logic [BYTE_W-1:0]    ops_dec, plen_dec;

    assign b        = item.frame_byte;
    assign ops_dec  = ops_reg - 8'd1;
    assign plen_dec = plen_reg - 8'd1;

    always_comb
    begin
        stage_next  = stage_reg;
        idx_next    = idx_reg;
        failed_next = failed_reg;
        ops_next    = ops_reg;
        plen_next   = plen_reg;
        prop_next   = prop_reg;
        trans_next  = trans_reg;
        sclass_next = sclass_reg;
        sinst_next  = sinst_reg;
        dclass_next = dclass_reg;
        dinst_next  = dinst_reg;
        svc_next    = svc_reg;
        complete    = 1'b0;
        act         = '0;

        case (stage_reg)
            ST_HEADER:
            begin
                case (idx_reg)
                    4'd0:          failed_next = failed_reg | (b != exp_one_reg);
                    4'd1:          failed_next = failed_reg | (b != exp_two_reg);
                    4'd2, 4'd3:    trans_next  = {trans_reg[BYTE_W-1:0], b};
                    4'd4, 4'd5:    sclass_next = {sclass_reg[BYTE_W-1:0], b};
                    4'd6:          sinst_next  = b;
                    4'd7, 4'd8:    dclass_next = {dclass_reg[BYTE_W-1:0], b};
                    4'd9:          dinst_next  = b;
                    4'd10:         svc_next    = b;
                    default:       ;
                endcase
                if (idx_reg >= HDR_LAST_IDX)
                begin
                    idx_next = '0;
                    if (failed_reg)
                    begin
                        stage_next = ST_FAILED;
                    end
                    else
                    begin
                        act.main_valid                   = 1'b1;
                        act.main_rec.record_kind         = KIND_HEADER;
                        act.main_rec.transaction_id      = trans_reg;
                        act.main_rec.source_class        = sclass_reg;
                        act.main_rec.source_instance     = sinst_reg;
                        act.main_rec.dest_class          = dclass_reg;
                        act.main_rec.dest_instance       = dinst_reg;
                        act.main_rec.service_code        = svc_reg;
                        act.main_rec.operation_count     = b;
                        ops_next   = b;
                        stage_next = (b == '0) ? ST_DONE : ST_CODE;
                        complete   = (b == '0);
                    end
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            ST_CODE:
            begin
                prop_next  = b;
                stage_next = ST_LEN;
            end
            ST_LEN:
            begin
                act.main_valid               = 1'b1;
                act.main_rec.record_kind     = KIND_PROP;
                act.main_rec.property_code   = prop_reg;
                act.main_rec.property_length = b;
                plen_next = b;
                if (b == '0)
                begin
                    ops_next   = ops_dec;
                    stage_next = (ops_dec == '0) ? ST_DONE : ST_CODE;
                    complete   = (ops_dec == '0);
                end
                else
                begin
                    stage_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                act.main_valid            = 1'b1;
                act.main_rec.record_kind  = KIND_DATA;
                act.main_rec.payload_byte = b;
                plen_next = plen_dec;
                if (plen_dec == '0)
                begin
                    ops_next   = ops_dec;
                    stage_next = (ops_dec == '0) ? ST_DONE : ST_CODE;
                    complete   = (ops_dec == '0);
                end
            end
            ST_DONE:
            begin
                complete = 1'b1;
            end
            default:
            begin
                // Failed header: drop bytes until the frame ends.
            end
        endcase

        if (item.end_of_frame)
        begin
            act.end_valid  = 1'b1;
            act.end_accept = complete;
            stage_next     = ST_HEADER;
            idx_next       = '0;
            failed_next    = 1'b0;
        end
        act.main_rec.last_of_run = ~item.end_of_frame;
    end

    assign act_valid = take & (act.main_valid | act.end_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_one_reg <= HEADER_ONE_RESET;
            exp_two_reg <= HEADER_TWO_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_HEADER_ONE)
            begin
                exp_one_reg <= cfg_data;
            end
            if (cfg_index == CFG_HEADER_TWO)
            begin
                exp_two_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= ST_HEADER;
            idx_reg    <= '0;
            failed_reg <= 1'b0;
            ops_reg    <= '0;
            plen_reg   <= '0;
            prop_reg   <= '0;
            trans_reg  <= '0;
            sclass_reg <= '0;
            sinst_reg  <= '0;
            dclass_reg <= '0;
            dinst_reg  <= '0;
            svc_reg    <= '0;
        end
        else if (take)
        begin
            stage_reg  <= stage_next;
            idx_reg    <= idx_next;
            failed_reg <= failed_next;
            ops_reg    <= ops_next;
            plen_reg   <= plen_next;
            prop_reg   <= prop_next;
            trans_reg  <= trans_next;
            sclass_reg <= sclass_next;
            sinst_reg  <= sinst_next;
            dclass_reg <= dclass_next;
            dinst_reg  <= dinst_next;
            svc_reg    <= svc_next;
        end
    end

endmodule

// File: rtl/efp_queue.sv
// Action queue between the front end and the record sequencer.
module efp_queue #(
    parameter int unsigned DEPTH = efp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  efp_pkg::action_t wr_data,
    input  logic             rd_en,
    output efp_pkg::action_t rd_data,
    output efp_pkg::q_status_t status
);
    import efp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    action_t          entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en & ~status.full;
    assign do_rd        = rd_en & ~status.empty;
    assign rd_data      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// File: rtl/efp_back.sv
// Back end: turns each queued action into one or two result records.
module efp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  efp_pkg::action_t   head,
    input  efp_pkg::q_status_t q_status,
    input  logic               pop,
    output logic               q_pop,
    output logic               empty,
    output efp_pkg::result_t   result
);
    import efp_pkg::*;

    logic phase_reg, phase_next;
    logic show_main;
    logic take;

    assign empty     = q_status.empty;
    assign show_main = head.main_valid & ~phase_reg;
    assign take      = pop & ~q_status.empty;
    // Hold the entry while its end verdict still has to follow the main record.
    assign q_pop     = take & ~(show_main & head.end_valid);

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = ~q_pop;
        end
    end

    always_comb
    begin
        if (show_main)
        begin
            result = head.main_rec;
        end
        else
        begin
            result             = '0;
            result.record_kind = head.end_accept ? KIND_ACCEPT : KIND_REJECT;
            result.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: rtl/echonet_frame_parser.sv
// Top level of the frame parser: front end, action queue and record sequencer.
//
// Frame bytes enter one per cycle through push/full; full only rises when the
// action queue (QUEUE_DEPTH entries) between the front end and the record
// sequencer is full. The front end checks the two header bytes against the
// configured values, gathers the header fields and walks the property
// operations. A byte that produces records leaves one queue entry: a header,
// property or payload record, an accept or reject verdict on the frame's last
// byte, or both. The sequencer shows the oldest record on the result port
// while empty is low and delivers one record per pop, so a byte that carries
// both a record and a verdict occupies the result port for two pops; bytes
// that produce nothing never reach the queue. Sustained throughput is one byte
// per cycle, bounded by one record per cycle on the result side. The expected
// header bytes are written through the configuration port (always ready); the
// user writes them only while the block is idle; the block does not enforce it.
module echonet_frame_parser #(
    parameter int unsigned QUEUE_DEPTH = efp_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  efp_pkg::item_t                  item,
    output logic                            empty,
    input  logic                            pop,
    output efp_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [efp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [efp_pkg::BYTE_W-1:0]      cfg_data
);
    import efp_pkg::*;

    action_t   act;
    action_t   head;
    logic      act_valid;
    logic      take;
    logic      q_pop;
    q_status_t q_status;

    // Accept a request whenever the queue has room.
    assign full      = q_status.full;
    assign take      = push & ~q_status.full;
    assign cfg_ready = 1'b1;

    efp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .act_valid (act_valid),
        .act       (act)
    );

    efp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (act_valid),
        .wr_data (act),
        .rd_en   (q_pop),
        .rd_data (head),
        .status  (q_status)
    );

    efp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .q_pop    (q_pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

// File: rtl/efp_checker.sv
// Port-level checks on the frame parser, bound to the top level.
module efp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input efp_pkg::result_t result
);
    import efp_pkg::*;

    // Come out of reset with nothing to deliver.
    a_empty_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.record_kind <= KIND_REJECT))
        else $error("record kind out of range");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.record_kind == KIND_ACCEPT || result.record_kind == KIND_REJECT))
        |-> result.last_of_run)
        else $error("verdict record not marked last");

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.record_kind == KIND_HEADER)
        |-> (result.property_code == '0 && result.property_length == '0
             && result.payload_byte == '0))
        else $error("header record carries property fields");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled record changed");

endmodule

bind echonet_frame_parser efp_checker u_efp_checker (.*);
